// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the pulsed lock driver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/pld_pkg.sv
// Package with constants and register codes of the pulsed lock driver.
package pld_pkg;

    localparam int TIME_WIDTH_DEF  = 32;
    localparam int LEVEL_WIDTH_DEF = 16;

    localparam int PULSE_WIDTH = 16;
    localparam int CLOSE_WIDTH = 24;
    localparam int ADDR_WIDTH  = 4;
    localparam int DATA_WIDTH  = 32;

    localparam logic [PULSE_WIDTH-1:0] PULSE_RESET = 16'd100;
    localparam logic [CLOSE_WIDTH-1:0] CLOSE_RESET = 24'd10000;
    localparam int                     WEIGHT_RESET    = 6554;
    localparam int                     THRESHOLD_RESET = 45875;

    typedef enum logic [1:0] {
        REG_PULSE_TIME  = 2'd0,
        REG_AUTO_CLOSE  = 2'd1,
        REG_WEIGHT      = 2'd2,
        REG_THRESHOLD   = 2'd3
    } reg_index_t;

endpackage

// File: src/pld_filter.sv
// Moving average update of the lock switch level.
module pld_filter
    import pld_pkg::*;
#(
    parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEF
)
(
    input  logic [LEVEL_WIDTH-1:0] level,
    input  logic [LEVEL_WIDTH:0]   weight,
    input  logic                   pin,
    output logic [LEVEL_WIDTH-1:0] level_next
);

    localparam int PW = 2 * LEVEL_WIDTH + 1;
    localparam logic [LEVEL_WIDTH:0] ONE = {1'b1, {LEVEL_WIDTH{1'b0}}};

    logic [LEVEL_WIDTH:0]   w_sat;
    logic [LEVEL_WIDTH:0]   w_keep;
    logic [PW-1:0]          keep_prod;
    logic [PW-1:0]          gain;
    logic [PW:0]            acc;
    logic [LEVEL_WIDTH+1:0] shifted;

    assign w_sat     = (weight > ONE) ? ONE : weight;
    assign w_keep    = ONE - w_sat;
    assign keep_prod = PW'(w_keep) * PW'(level);
    assign gain      = pin ? {w_sat, {LEVEL_WIDTH{1'b0}}} : '0;
    assign acc       = (PW + 1)'(gain) + (PW + 1)'(keep_prod);
    assign shifted   = acc[PW:LEVEL_WIDTH];

    always_comb
    begin
        if (shifted[LEVEL_WIDTH+1:LEVEL_WIDTH] != 2'b00)
        begin
            level_next = '1;
        end
        else
        begin
            level_next = shifted[LEVEL_WIDTH-1:0];
        end
    end

endmodule

// File: src/pulsed_lock_driver_with_auto_close_unit.sv
// Top level of the pulsed lock driver with auto close.
//
// Input channel: item_valid / item_stall carry one transaction per step with
// a timestamp and event flags. Output channel: result_valid / result_stall
// return one result transaction per input transaction, in order.
// An accepted item lands in an input register; when the result register is
// empty or being drained, its step is computed and written to the result
// register, which drives result_valid. Throughput is one item per cycle
// while result_stall is low, set by the combinational state update between
// the input and result registers. When the receiver stalls, one further
// item is held in the input register; item_stall rises only while both
// registers are full and result_stall is high. Reset clears the lock state,
// the filter level and both registers' valid bits, and loads the configuration
// defaults. The APB port writes the registers pulse_time_ms, auto_close_ms,
// filter_weight and press_threshold at byte addresses 0, 4, 8 and 12; pready
// is always high and reads return the stored values. Configuration must be
// written only while the block is idle; the block itself does not enforce it.
module pulsed_lock_driver_with_auto_close_unit
    import pld_pkg::*;
#(
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_WIDTH-1:0]  paddr,
    input  logic [DATA_WIDTH-1:0]  pwdata,
    output logic [DATA_WIDTH-1:0]  prdata,
    output logic                   pready,

    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic [TIME_WIDTH-1:0]  now_ms,
    input  logic                   unlock_request,
    input  logic                   set_request_valid,
    input  logic                   set_request_open,
    input  logic                   clear_in_progress,
    input  logic                   clear_timeout_flag,
    input  logic                   sample_valid,
    input  logic                   sample_bit,

    output logic                   result_valid,
    input  logic                   result_stall,
    output logic                   drive_open,
    output logic                   drive_close,
    output logic                   lock_open_requested,
    output logic                   opening_in_progress,
    output logic                   auto_close_fired,
    output logic                   switch_pushed,
    output logic [LEVEL_WIDTH-1:0] switch_level
);

    `include "assert_macros.svh"

    localparam int CMP_W = (TIME_WIDTH > CLOSE_WIDTH) ? TIME_WIDTH : CLOSE_WIDTH;

    // configuration
    logic [PULSE_WIDTH-1:0] pulse_reg;
    logic [CLOSE_WIDTH-1:0] close_reg;
    logic [LEVEL_WIDTH:0]   weight_reg;
    logic [LEVEL_WIDTH-1:0] thr_reg;
    logic                   cfg_write;
    reg_index_t             cfg_idx;

    // input register
    logic                   in_valid_reg;
    logic [TIME_WIDTH-1:0]  now_reg;
    logic                   unlock_reg;
    logic                   set_valid_reg;
    logic                   set_open_reg;
    logic                   clr_prog_reg;
    logic                   clr_tmo_reg;
    logic                   smp_valid_reg;
    logic                   smp_bit_reg;

    // lock state
    logic                   requested_open_reg;
    logic                   applied_open_reg;
    logic [TIME_WIDTH-1:0]  last_change_reg;
    logic [TIME_WIDTH-1:0]  last_unlock_reg;
    logic                   in_progress_reg;
    logic                   timeout_reg;
    logic [LEVEL_WIDTH-1:0] level_reg;
    logic                   open_coil_reg;
    logic                   close_coil_reg;

    logic                   requested_open_next;
    logic                   applied_open_next;
    logic [TIME_WIDTH-1:0]  last_change_next;
    logic [TIME_WIDTH-1:0]  last_unlock_next;
    logic                   in_progress_next;
    logic                   timeout_next;
    logic [LEVEL_WIDTH-1:0] level_next;
    logic                   open_coil_next;
    logic                   close_coil_next;
    logic [LEVEL_WIDTH-1:0] filt_level;
    logic [TIME_WIDTH-1:0]  since_change;
    logic [TIME_WIDTH-1:0]  since_unlock;

    // result register
    logic                   out_valid_reg;
    logic                   item_accept;
    logic                   advance;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg  <= PULSE_RESET;
            close_reg  <= CLOSE_RESET;
            weight_reg <= (LEVEL_WIDTH + 1)'(WEIGHT_RESET);
            thr_reg    <= LEVEL_WIDTH'(THRESHOLD_RESET);
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_PULSE_TIME: pulse_reg  <= pwdata[PULSE_WIDTH-1:0];
                REG_AUTO_CLOSE: close_reg  <= pwdata[CLOSE_WIDTH-1:0];
                REG_WEIGHT:     weight_reg <= pwdata[LEVEL_WIDTH:0];
                REG_THRESHOLD:  thr_reg    <= pwdata[LEVEL_WIDTH-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_PULSE_TIME: prdata = DATA_WIDTH'(pulse_reg);
            REG_AUTO_CLOSE: prdata = DATA_WIDTH'(close_reg);
            REG_WEIGHT:     prdata = DATA_WIDTH'(weight_reg);
            REG_THRESHOLD:  prdata = DATA_WIDTH'(thr_reg);
            default:        prdata = '0;
        endcase
    end

    // handshake
    assign advance     = in_valid_reg && !(out_valid_reg && result_stall);
    assign item_stall  = in_valid_reg && out_valid_reg && result_stall;
    assign item_accept = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            now_reg       <= now_ms;
            unlock_reg    <= unlock_request;
            set_valid_reg <= set_request_valid;
            set_open_reg  <= set_request_open;
            clr_prog_reg  <= clear_in_progress;
            clr_tmo_reg   <= clear_timeout_flag;
            smp_valid_reg <= sample_valid;
            smp_bit_reg   <= sample_bit;
        end
    end

    pld_filter #(
        .LEVEL_WIDTH (LEVEL_WIDTH)
    ) u_filter (
        .level      (level_reg),
        .weight     (weight_reg),
        .pin        (smp_bit_reg),
        .level_next (filt_level)
    );

    // one step of the lock control
    always_comb
    begin
        requested_open_next = requested_open_reg;
        applied_open_next   = applied_open_reg;
        last_change_next    = last_change_reg;
        last_unlock_next    = last_unlock_reg;
        in_progress_next    = in_progress_reg;
        timeout_next        = timeout_reg;
        open_coil_next      = open_coil_reg;
        close_coil_next     = close_coil_reg;

        if (set_valid_reg)
        begin
            requested_open_next = set_open_reg;
        end
        if (unlock_reg && !in_progress_reg)
        begin
            requested_open_next = 1'b1;
            last_unlock_next    = now_reg;
            in_progress_next    = 1'b1;
        end
        if (clr_prog_reg)
        begin
            in_progress_next = 1'b0;
        end
        if (clr_tmo_reg)
        begin
            timeout_next = 1'b0;
        end
        level_next = smp_valid_reg ? filt_level : level_reg;

        since_change = now_reg - last_change_reg;
        since_unlock = now_reg - last_unlock_next;

        if (CMP_W'(since_change) >= CMP_W'(pulse_reg))
        begin
            if (requested_open_next != applied_open_reg)
            begin
                applied_open_next = requested_open_next;
                last_change_next  = now_reg;
                open_coil_next    = requested_open_next;
                close_coil_next   = !requested_open_next;
            end
            else
            begin
                open_coil_next  = 1'b0;
                close_coil_next = 1'b0;
            end
        end

        if (requested_open_next && (CMP_W'(since_unlock) > CMP_W'(close_reg)))
        begin
            requested_open_next = 1'b0;
            in_progress_next    = 1'b0;
            timeout_next        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            requested_open_reg <= 1'b0;
            applied_open_reg   <= 1'b0;
            last_change_reg    <= '0;
            last_unlock_reg    <= '0;
            in_progress_reg    <= 1'b0;
            timeout_reg        <= 1'b0;
            level_reg          <= '0;
            open_coil_reg      <= 1'b0;
            close_coil_reg     <= 1'b0;
        end
        else if (advance)
        begin
            requested_open_reg <= requested_open_next;
            applied_open_reg   <= applied_open_next;
            last_change_reg    <= last_change_next;
            last_unlock_reg    <= last_unlock_next;
            in_progress_reg    <= in_progress_next;
            timeout_reg        <= timeout_next;
            level_reg          <= level_next;
            open_coil_reg      <= open_coil_next;
            close_coil_reg     <= close_coil_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drive_open          <= open_coil_next;
            drive_close         <= close_coil_next;
            lock_open_requested <= requested_open_next;
            opening_in_progress <= in_progress_next;
            auto_close_fired    <= timeout_next;
            switch_pushed       <= (level_next > thr_reg);
            switch_level        <= level_next;
        end
    end

    assign result_valid = out_valid_reg;

    `ASSERT_IMPL(a_coils_exclusive, 1'b1, !(open_coil_reg && close_coil_reg))
    `ASSERT_IMPL(a_stall_only_full, item_stall, in_valid_reg && out_valid_reg)
    `ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg)
    `ASSERT_IMPL(a_timeout_withdraws, $rose(timeout_reg), !requested_open_reg)

endmodule
